// ===== hw/rtl/aeseax_pkg.sv =====
package aeseax_pkg;

    localparam int BLK_W = 128;
    localparam int WORD_W = 32;
    localparam int NUM_RK = 15;
    localparam int WIN_DEPTH = 8;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam logic [4:0] FULL_BYTES = 5'd16;
    localparam logic [3:0] ROUNDS_128 = 4'd10;
    localparam logic [3:0] ROUNDS_256 = 4'd14;
    localparam logic [5:0] FIRST_WORD_128 = 6'd4;
    localparam logic [5:0] FIRST_WORD_256 = 6'd8;
    localparam logic [5:0] LAST_WORD_128 = 6'd43;
    localparam logic [5:0] LAST_WORD_256 = 6'd59;
    localparam logic [2:0] SUB_ONLY_POS = 3'd4;
    localparam logic [7:0] DBL_POLY = 8'h87;
    localparam logic [7:0] MIX_POLY = 8'h1b;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [1:0] {
        OP_NONCE,
        OP_HEADER,
        OP_PAYLOAD,
        OP_TAG
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_TAG,
        KIND_VERDICT
    } kind_t;

    typedef enum logic [2:0] {
        REG_KEY_A,
        REG_KEY_B,
        REG_KEY_C,
        REG_KEY_D,
        REG_KEY_256,
        REG_DECRYPT
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_EXP,
        ST_KEY_ENC,
        ST_KEY_PAD,
        ST_DECIDE,
        ST_KS,
        ST_KS_POST,
        ST_EMIT_PAY,
        ST_ABSORB,
        ST_TWK,
        ST_TWK_POST,
        ST_MAC,
        ST_FIN,
        ST_EMIT_TAG,
        ST_EMIT_VER
    } state_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_CTR,
        SRC_TWEAK,
        SRC_EMPTY,
        SRC_MAC
    } src_t;

    typedef struct packed {
        logic key_init;
        logic key_step;
        logic aes_start;
        src_t aes_src;
        logic pad_store;
        logic ks_done;
        logic tweak_done;
        logic fin;
        logic emit_pay;
        logic emit_tag;
        logic emit_ver;
    } cmd_t;

    typedef struct packed {
        logic    key_last;
        logic    aes_last;
        opcode_t op;
        logic    last;
        logic    has_bytes;
        logic    started;
        logic    decrypt;
        logic    out_free;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? MIX_POLY : 8'h00);
    endfunction

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [BLK_W-1:0] dbl(input logic [BLK_W-1:0] x);
        return {x[BLK_W-2:0], 1'b0} ^ (x[BLK_W-1] ? {{(BLK_W-8){1'b0}}, DBL_POLY} : '0);
    endfunction

    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic             final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [BLK_W-1:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = SBOX[s[BLK_W - 1 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
            end
        end
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                t[4 * c]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4 * c + 1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4 * c + 2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4 * c + 3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int b = 0; b < 16; b++) begin
            r[BLK_W - 1 - 8 * b -: 8] = t[b];
        end
        return r ^ rk;
    endfunction

endpackage

// ===== hw/rtl/aeseax_in_if.sv =====
interface aeseax_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  byte_count;
    logic        segment_last;

    modport source (
        output valid, opcode, block_hi, block_lo, byte_count, segment_last,
        input  ready
    );

    modport sink (
        input  valid, opcode, block_hi, block_lo, byte_count, segment_last,
        output ready
    );
endinterface

// ===== hw/rtl/aeseax_out_if.sv =====
interface aeseax_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        tag_ok;
    logic        run_last;

    modport source (
        output valid, kind, out_hi, out_lo, out_bytes, tag_ok, run_last,
        input  ready
    );

    modport sink (
        input  valid, kind, out_hi, out_lo, out_bytes, tag_ok, run_last,
        output ready
    );
endinterface

// ===== hw/rtl/aeseax_ctrl.sv =====
module aeseax_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic                in_valid,
    output logic                in_ready,
    input  aeseax_pkg::status_t st,
    output aeseax_pkg::cmd_t    cmd
);

    aeseax_pkg::state_t state_reg;
    aeseax_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aeseax_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aeseax_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = aeseax_pkg::ST_DECIDE;
                end
            end
            aeseax_pkg::ST_KEY_EXP:
            begin
                if (st.key_last)
                begin
                    state_next = aeseax_pkg::ST_KEY_ENC;
                end
            end
            aeseax_pkg::ST_KEY_ENC:
            begin
                if (st.aes_last)
                begin
                    state_next = aeseax_pkg::ST_KEY_PAD;
                end
            end
            aeseax_pkg::ST_KEY_PAD:
            begin
                state_next = aeseax_pkg::ST_IDLE;
            end
            aeseax_pkg::ST_DECIDE:
            begin
                if (st.op == aeseax_pkg::OP_TAG)
                begin
                    state_next = st.decrypt ? aeseax_pkg::ST_EMIT_VER : aeseax_pkg::ST_IDLE;
                end
                else if (st.op == aeseax_pkg::OP_PAYLOAD && st.has_bytes)
                begin
                    state_next = aeseax_pkg::ST_KS;
                end
                else
                begin
                    state_next = aeseax_pkg::ST_ABSORB;
                end
            end
            aeseax_pkg::ST_KS:
            begin
                if (st.aes_last)
                begin
                    state_next = aeseax_pkg::ST_KS_POST;
                end
            end
            aeseax_pkg::ST_KS_POST:
            begin
                state_next = aeseax_pkg::ST_EMIT_PAY;
            end
            aeseax_pkg::ST_EMIT_PAY:
            begin
                if (st.out_free)
                begin
                    state_next = aeseax_pkg::ST_ABSORB;
                end
            end
            aeseax_pkg::ST_ABSORB:
            begin
                if (!st.started && !(st.last && !st.has_bytes))
                begin
                    state_next = aeseax_pkg::ST_TWK;
                end
                else
                begin
                    state_next = aeseax_pkg::ST_MAC;
                end
            end
            aeseax_pkg::ST_TWK:
            begin
                if (st.aes_last)
                begin
                    state_next = aeseax_pkg::ST_TWK_POST;
                end
            end
            aeseax_pkg::ST_TWK_POST:
            begin
                state_next = aeseax_pkg::ST_ABSORB;
            end
            aeseax_pkg::ST_MAC:
            begin
                if (st.aes_last)
                begin
                    state_next = aeseax_pkg::ST_FIN;
                end
            end
            aeseax_pkg::ST_FIN:
            begin
                if (st.last && st.op == aeseax_pkg::OP_PAYLOAD && !st.decrypt)
                begin
                    state_next = aeseax_pkg::ST_EMIT_TAG;
                end
                else
                begin
                    state_next = aeseax_pkg::ST_IDLE;
                end
            end
            aeseax_pkg::ST_EMIT_TAG,
            aeseax_pkg::ST_EMIT_VER:
            begin
                if (st.out_free)
                begin
                    state_next = aeseax_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aeseax_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = aeseax_pkg::ST_KEY_EXP;
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.aes_src = aeseax_pkg::SRC_ZERO;
        in_ready = 1'b0;
        case (state_reg)
            aeseax_pkg::ST_IDLE:
            begin
                in_ready = !cfg_wr;
            end
            aeseax_pkg::ST_KEY_EXP:
            begin
                cmd.key_step = 1'b1;
                cmd.aes_start = st.key_last;
                cmd.aes_src = aeseax_pkg::SRC_ZERO;
            end
            aeseax_pkg::ST_KEY_PAD:
            begin
                cmd.pad_store = 1'b1;
            end
            aeseax_pkg::ST_DECIDE:
            begin
                if (st.op == aeseax_pkg::OP_PAYLOAD && st.has_bytes)
                begin
                    cmd.aes_start = 1'b1;
                    cmd.aes_src = aeseax_pkg::SRC_CTR;
                end
            end
            aeseax_pkg::ST_KS_POST:
            begin
                cmd.ks_done = 1'b1;
            end
            aeseax_pkg::ST_EMIT_PAY:
            begin
                cmd.emit_pay = st.out_free;
            end
            aeseax_pkg::ST_ABSORB:
            begin
                cmd.aes_start = 1'b1;
                if (st.started)
                begin
                    cmd.aes_src = aeseax_pkg::SRC_MAC;
                end
                else if (st.last && !st.has_bytes)
                begin
                    cmd.aes_src = aeseax_pkg::SRC_EMPTY;
                end
                else
                begin
                    cmd.aes_src = aeseax_pkg::SRC_TWEAK;
                end
            end
            aeseax_pkg::ST_TWK_POST:
            begin
                cmd.tweak_done = 1'b1;
            end
            aeseax_pkg::ST_FIN:
            begin
                cmd.fin = 1'b1;
            end
            aeseax_pkg::ST_EMIT_TAG:
            begin
                cmd.emit_tag = st.out_free;
            end
            aeseax_pkg::ST_EMIT_VER:
            begin
                cmd.emit_ver = st.out_free;
            end
            default:
            begin
                cmd.key_step = 1'b0;
            end
        endcase
        if (cfg_wr)
        begin
            cmd = '0;
            cmd.aes_src = aeseax_pkg::SRC_ZERO;
            cmd.key_init = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/aeseax_dp.sv =====
module aeseax_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  aeseax_pkg::cmd_t    cmd,
    output aeseax_pkg::status_t st,
    input  logic [63:0]         key_a,
    input  logic [63:0]         key_b,
    input  logic [63:0]         key_c,
    input  logic [63:0]         key_d,
    input  logic                key_256,
    input  logic                decrypt,
    input  logic                in_take,
    input  logic [1:0]          in_opcode,
    input  logic [63:0]         in_block_hi,
    input  logic [63:0]         in_block_lo,
    input  logic [4:0]          in_byte_count,
    input  logic                in_segment_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_kind,
    output logic [63:0]         out_hi,
    output logic [63:0]         out_lo,
    output logic [4:0]          out_bytes,
    output logic                out_tag_ok,
    output logic                out_run_last
);

    localparam int BW = aeseax_pkg::BLK_W;
    localparam int WW = aeseax_pkg::WORD_W;

    // key schedule
    logic [WW-1:0] win_reg [aeseax_pkg::WIN_DEPTH];
    logic [WW-1:0] win_next [aeseax_pkg::WIN_DEPTH];
    logic [5:0]    widx_reg, widx_next;
    logic [BW-1:0] rk_reg [aeseax_pkg::NUM_RK];
    logic [BW-1:0] rk_next [aeseax_pkg::NUM_RK];
    logic [BW-1:0] pad_full_reg, pad_full_next;
    logic [BW-1:0] pad_part_reg, pad_part_next;

    // cipher round unit
    logic [BW-1:0] s_reg, s_next;
    logic [3:0]    rnd_reg, rnd_next;
    logic          busy_reg, busy_next;

    // mac and counter state
    logic [BW-1:0] omac_reg, omac_next;
    logic [BW-1:0] nonce_reg, nonce_next;
    logic [BW-1:0] header_reg, header_next;
    logic [BW-1:0] ctr_reg, ctr_next;
    logic          started_reg, started_next;

    // current item
    aeseax_pkg::opcode_t op_reg, op_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [4:0]    n_reg, n_next;
    logic          last_reg, last_next;
    logic [BW-1:0] res_reg, res_next;

    // output register
    logic          ovalid_reg, ovalid_next;
    aeseax_pkg::kind_t okind_reg, okind_next;
    logic [BW-1:0] odata_reg, odata_next;
    logic [4:0]    obytes_reg, obytes_next;
    logic          ook_reg, ook_next;
    logic          orlast_reg, orlast_next;

    logic [WW-1:0] kbw [8];
    logic [3:0]    nr;
    logic [WW-1:0] kt, kw;
    logic [3:0]    rcon_idx;
    logic [BW-1:0] src_blk;
    logic [BW-1:0] tweak_blk;
    logic [BW-1:0] pad_vec;
    logic [BW-1:0] item_mask;
    logic [BW-1:0] want;
    logic [BW-1:0] in_blk;
    logic [4:0]    in_nsat;
    logic [4:0]    in_n;
    logic          out_free;

    assign kbw[0] = key_a[63:32];
    assign kbw[1] = key_a[31:0];
    assign kbw[2] = key_b[63:32];
    assign kbw[3] = key_b[31:0];
    assign kbw[4] = key_c[63:32];
    assign kbw[5] = key_c[31:0];
    assign kbw[6] = key_d[63:32];
    assign kbw[7] = key_d[31:0];

    assign nr = key_256 ? aeseax_pkg::ROUNDS_256 : aeseax_pkg::ROUNDS_128;
    assign tweak_blk = {{(BW-2){1'b0}}, op_reg};
    assign item_mask = ~({BW{1'b1}} >> {n_reg, 3'b000});
    assign pad_vec = (n_reg == aeseax_pkg::FULL_BYTES) ? pad_full_reg
                   : (pad_part_reg ^ ({aeseax_pkg::PAD_BYTE, {(BW-8){1'b0}}} >> {n_reg, 3'b000}));
    assign want = omac_reg ^ nonce_reg ^ header_reg;
    assign out_free = !ovalid_reg || out_ready;

    assign in_blk = {in_block_hi, in_block_lo};
    assign in_nsat = (in_byte_count > aeseax_pkg::FULL_BYTES) ? aeseax_pkg::FULL_BYTES
                                                              : in_byte_count;
    assign in_n = in_segment_last ? in_nsat : aeseax_pkg::FULL_BYTES;

    assign rcon_idx = key_256 ? {1'b0, widx_reg[5:3]} : widx_reg[5:2];

    // next key word
    always_comb
    begin
        kt = win_reg[0];
        if (key_256 ? (widx_reg[2:0] == 3'd0) : (widx_reg[1:0] == 2'd0))
        begin
            kt = aeseax_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                 ^ {aeseax_pkg::rcon(rcon_idx), 24'h000000};
        end
        else if (key_256 && widx_reg[2:0] == aeseax_pkg::SUB_ONLY_POS)
        begin
            kt = aeseax_pkg::sub_word(win_reg[0]);
        end
        kw = (key_256 ? win_reg[7] : win_reg[3]) ^ kt;
    end

    always_comb
    begin
        case (cmd.aes_src)
            aeseax_pkg::SRC_ZERO:  src_blk = '0;
            aeseax_pkg::SRC_CTR:   src_blk = ctr_reg;
            aeseax_pkg::SRC_TWEAK: src_blk = tweak_blk;
            aeseax_pkg::SRC_EMPTY: src_blk = tweak_blk ^ pad_full_reg;
            aeseax_pkg::SRC_MAC:   src_blk = omac_reg ^ blk_reg ^ (last_reg ? pad_vec : '0);
            default:               src_blk = '0;
        endcase
    end

    always_comb
    begin
        win_next = win_reg;
        widx_next = widx_reg;
        rk_next = rk_reg;
        pad_full_next = pad_full_reg;
        pad_part_next = pad_part_reg;
        s_next = s_reg;
        rnd_next = rnd_reg;
        busy_next = busy_reg;
        omac_next = omac_reg;
        nonce_next = nonce_reg;
        header_next = header_reg;
        ctr_next = ctr_reg;
        started_next = started_reg;
        op_next = op_reg;
        blk_next = blk_reg;
        n_next = n_reg;
        last_next = last_reg;
        res_next = res_reg;
        ovalid_next = ovalid_reg;
        okind_next = okind_reg;
        odata_next = odata_reg;
        obytes_next = obytes_reg;
        ook_next = ook_reg;
        orlast_next = orlast_reg;

        if (cmd.key_init)
        begin
            for (int j = 0; j < aeseax_pkg::WIN_DEPTH; j++)
            begin
                if (key_256)
                begin
                    win_next[j] = kbw[7 - j];
                end
                else if (j < 4)
                begin
                    win_next[j] = kbw[3 - j];
                end
                else
                begin
                    win_next[j] = '0;
                end
            end
            widx_next = key_256 ? aeseax_pkg::FIRST_WORD_256 : aeseax_pkg::FIRST_WORD_128;
            rk_next[0] = {key_a, key_b};
            rk_next[1] = {key_c, key_d};
        end
        else if (cmd.key_step)
        begin
            for (int j = aeseax_pkg::WIN_DEPTH - 1; j > 0; j--)
            begin
                win_next[j] = win_reg[j - 1];
            end
            win_next[0] = kw;
            widx_next = widx_reg + 6'd1;
            rk_next[widx_reg[5:2]][(3 - widx_reg[1:0]) * WW +: WW] = kw;
        end

        if (cmd.aes_start)
        begin
            s_next = src_blk ^ rk_reg[0];
            rnd_next = 4'd1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            s_next = aeseax_pkg::aes_round(s_reg, rk_reg[rnd_reg], rnd_reg == nr);
            rnd_next = rnd_reg + 4'd1;
            busy_next = (rnd_reg != nr);
        end

        if (cmd.pad_store)
        begin
            pad_full_next = aeseax_pkg::dbl(s_reg);
            pad_part_next = aeseax_pkg::dbl(aeseax_pkg::dbl(s_reg));
        end

        if (in_take)
        begin
            op_next = aeseax_pkg::opcode_t'(in_opcode);
            n_next = in_n;
            last_next = in_segment_last;
            if (aeseax_pkg::opcode_t'(in_opcode) == aeseax_pkg::OP_TAG)
            begin
                blk_next = in_blk;
            end
            else
            begin
                blk_next = in_blk & ~({BW{1'b1}} >> {in_n, 3'b000});
            end
            if (aeseax_pkg::opcode_t'(in_opcode) == aeseax_pkg::OP_PAYLOAD && !started_reg)
            begin
                ctr_next = nonce_reg;
            end
        end

        if (cmd.ks_done)
        begin
            res_next = (blk_reg ^ s_reg) & item_mask;
            if (!decrypt)
            begin
                blk_next = (blk_reg ^ s_reg) & item_mask;
            end
            ctr_next = ctr_reg + {{(BW-1){1'b0}}, 1'b1};
        end

        if (cmd.tweak_done)
        begin
            omac_next = s_reg;
            started_next = 1'b1;
        end

        if (cmd.fin)
        begin
            omac_next = s_reg;
            started_next = !last_reg;
            if (last_reg && op_reg == aeseax_pkg::OP_NONCE)
            begin
                nonce_next = s_reg;
            end
            if (last_reg && op_reg == aeseax_pkg::OP_HEADER)
            begin
                header_next = s_reg;
            end
        end

        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.emit_pay)
        begin
            ovalid_next = 1'b1;
            okind_next = aeseax_pkg::KIND_PAYLOAD;
            odata_next = res_reg;
            obytes_next = n_reg;
            ook_next = 1'b0;
            orlast_next = !(last_reg && !decrypt);
        end
        else if (cmd.emit_tag)
        begin
            ovalid_next = 1'b1;
            okind_next = aeseax_pkg::KIND_TAG;
            odata_next = want;
            obytes_next = aeseax_pkg::FULL_BYTES;
            ook_next = 1'b0;
            orlast_next = 1'b1;
        end
        else if (cmd.emit_ver)
        begin
            ovalid_next = 1'b1;
            okind_next = aeseax_pkg::KIND_VERDICT;
            odata_next = '0;
            obytes_next = 5'd0;
            ook_next = (want == blk_reg);
            orlast_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            omac_reg <= '0;
            nonce_reg <= '0;
            header_reg <= '0;
            ctr_reg <= '0;
            started_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            omac_reg <= omac_next;
            nonce_reg <= nonce_next;
            header_reg <= header_next;
            ctr_reg <= ctr_next;
            started_reg <= started_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        widx_reg <= widx_next;
        rk_reg <= rk_next;
        pad_full_reg <= pad_full_next;
        pad_part_reg <= pad_part_next;
        s_reg <= s_next;
        rnd_reg <= rnd_next;
        op_reg <= op_next;
        blk_reg <= blk_next;
        n_reg <= n_next;
        last_reg <= last_next;
        res_reg <= res_next;
        okind_reg <= okind_next;
        odata_reg <= odata_next;
        obytes_reg <= obytes_next;
        ook_reg <= ook_next;
        orlast_reg <= orlast_next;
    end

    always_comb
    begin
        st.key_last = widx_reg == (key_256 ? aeseax_pkg::LAST_WORD_256
                                           : aeseax_pkg::LAST_WORD_128);
        st.aes_last = busy_reg && (rnd_reg == nr);
        st.op = op_reg;
        st.last = last_reg;
        st.has_bytes = (n_reg != 5'd0);
        st.started = started_reg;
        st.decrypt = decrypt;
        st.out_free = out_free;
    end

    assign out_valid = ovalid_reg;
    assign out_kind = okind_reg;
    assign out_hi = odata_reg[BW-1:BW/2];
    assign out_lo = odata_reg[BW/2-1:0];
    assign out_bytes = obytes_reg;
    assign out_tag_ok = ook_reg;
    assign out_run_last = orlast_reg;

endmodule

// ===== hw/rtl/aes_eax_aead_engine_core.sv =====
// channel   dir  handshake       payload
// din       in   valid/ready     opcode, block_hi, block_lo, byte_count, segment_last
// dout      out  valid/ready     kind, out_hi, out_lo, out_bytes, tag_ok, run_last
// apb       in   psel/penable    paddr, pwdata, prdata (64-bit registers at 8*i)
//
// one shared aes round unit, one round per cycle (nr = 10 or 14)
// payload block: keystream pass and emit, then mac pass, plus a tweak pass when it opens
// a segment; nonce/header block: mac pass, plus a tweak pass likewise; tag: decrypt verdict
// a register write re-runs key expansion (4*nr+4-nk words) and E(0) with din not ready;
// after reset the key registers are zero and the round keys unset until the first write
// a stalled dout holds the engine in its emit step; the next item waits for idle
module aes_eax_aead_engine_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [aeseax_pkg::ADDR_W-1:0]         paddr,
    input  logic [aeseax_pkg::DATA_W-1:0]         pwdata,
    output logic [aeseax_pkg::DATA_W-1:0]         prdata,
    output logic                                  pready,
    aeseax_in_if.sink                             din,
    aeseax_out_if.source                          dout
);

    logic [63:0] key_a_reg, key_a_next;
    logic [63:0] key_b_reg, key_b_next;
    logic [63:0] key_c_reg, key_c_next;
    logic [63:0] key_d_reg, key_d_next;
    logic        key_256_reg, key_256_next;
    logic        decrypt_reg, decrypt_next;

    aeseax_pkg::reg_idx_t  widx;
    logic                  apb_wr;
    logic                  cfg_wr;
    logic                  in_take;
    aeseax_pkg::cmd_t      cmd;
    aeseax_pkg::status_t   st;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;
    assign widx = aeseax_pkg::reg_idx_t'(paddr[5:3]);

    always_comb
    begin
        key_a_next = key_a_reg;
        key_b_next = key_b_reg;
        key_c_next = key_c_reg;
        key_d_next = key_d_reg;
        key_256_next = key_256_reg;
        decrypt_next = decrypt_reg;
        cfg_wr = 1'b0;
        prdata = '0;
        case (widx)
            aeseax_pkg::REG_KEY_A:
            begin
                prdata = key_a_reg;
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    key_a_next = pwdata;
                end
            end
            aeseax_pkg::REG_KEY_B:
            begin
                prdata = key_b_reg;
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    key_b_next = pwdata;
                end
            end
            aeseax_pkg::REG_KEY_C:
            begin
                prdata = key_c_reg;
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    key_c_next = pwdata;
                end
            end
            aeseax_pkg::REG_KEY_D:
            begin
                prdata = key_d_reg;
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    key_d_next = pwdata;
                end
            end
            aeseax_pkg::REG_KEY_256:
            begin
                prdata = {63'd0, key_256_reg};
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    key_256_next = pwdata[0];
                end
            end
            aeseax_pkg::REG_DECRYPT:
            begin
                prdata = {63'd0, decrypt_reg};
                cfg_wr = apb_wr;
                if (apb_wr)
                begin
                    decrypt_next = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= '0;
            key_b_reg <= '0;
            key_c_reg <= '0;
            key_d_reg <= '0;
            key_256_reg <= 1'b0;
            decrypt_reg <= 1'b0;
        end
        else
        begin
            key_a_reg <= key_a_next;
            key_b_reg <= key_b_next;
            key_c_reg <= key_c_next;
            key_d_reg <= key_d_next;
            key_256_reg <= key_256_next;
            decrypt_reg <= decrypt_next;
        end
    end

    assign in_take = din.valid && din.ready;

    aeseax_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // key load sees the value being written in the same cycle
    aeseax_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .key_a           (key_a_next),
        .key_b           (key_b_next),
        .key_c           (key_c_next),
        .key_d           (key_d_next),
        .key_256         (key_256_next),
        .decrypt         (decrypt_reg),
        .in_take         (in_take),
        .in_opcode       (din.opcode),
        .in_block_hi     (din.block_hi),
        .in_block_lo     (din.block_lo),
        .in_byte_count   (din.byte_count),
        .in_segment_last (din.segment_last),
        .out_valid       (dout.valid),
        .out_ready       (dout.ready),
        .out_kind        (dout.kind),
        .out_hi          (dout.out_hi),
        .out_lo          (dout.out_lo),
        .out_bytes       (dout.out_bytes),
        .out_tag_ok      (dout.tag_ok),
        .out_run_last    (dout.run_last)
    );

endmodule
